// File: rtl/gauss_pkg.sv
// ----------------------------------------------------------------------------
// gauss_pkg
// Shared constants and the store-address helper for the Gaussian elimination block.
// ----------------------------------------------------------------------------
package gauss_pkg;

  localparam int MAX_DIM     = 8;
  localparam int FRAC_BITS   = 16;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int ADDR_W      = 6;
  localparam int DEPTH       = 64;
  localparam int CNT_W       = 7;
  localparam int DATA_W      = 32;
  localparam int DIV_W       = DATA_W + 1 + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // Store address of a[r][c] at row stride n.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c,
                                                  input logic [DIM_W-1:0] n);
    logic [IDX_W+DIM_W:0] s;
    s = ({1'b0, DIM_W'(r)} * {1'b0, n}) + (IDX_W+DIM_W+1)'(c);
    return s[ADDR_W-1:0];
  endfunction

endpackage

// File: rtl/gaussian_elimination_upper.sv
// Loading: one element per cycle; the last element of the matrix starts elimination.
// Elimination: per lower row a bit-serial division for the factor, then each updated
// entry goes through the single store port (read, read, multiply, write).
// Emission: n*n results; the receiver cannot stall; busy stays high until the final
// result appears. Synchronous reset clears control state and sets n_used to 8; the
// matrix store itself is not cleared.
// ----------------------------------------------------------------------------
// gaussian_elimination_upper
// Collects an n by n Q16.16 matrix, runs forward elimination without pivoting
// in one synchronous store, and emits the upper-triangular result row-major.
// ----------------------------------------------------------------------------
module gaussian_elimination_upper
  import gauss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] element,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [DIM_W-1:0]         cfg_data,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] value,
  output logic [IDX_W-1:0]         row_index,
  output logic [IDX_W-1:0]         col_index,
  output logic                     last_of_matrix,
  output logic                     zero_pivot
);

  typedef enum logic [3:0] {
    S_IDLE, S_PIV, S_PIVD, S_WK, S_WKD, S_DIV, S_DIVF,
    S_J, S_JA, S_JB, S_JW, S_ER, S_EO
  } state_t;

  state_t state;

  logic [DIM_W-1:0]           n_used;
  logic [CNT_W-1:0]           load_count;
  logic [IDX_W-1:0]           k, w, j, r, c;
  logic                       pivot_error;
  logic signed [DATA_W-1:0]   piv, fac, akj, awj;
  logic signed [2*DATA_W-1:0] prod;
  logic [DIV_W-1:0]           dq;
  logic [DATA_W:0]            rem;
  logic [DATA_W-1:0]          piv_mag;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic                       neg;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     we;
  logic signed [DATA_W-1:0] wdata;

  logic [DIM_W-1:0]   n;
  logic [CNT_W-1:0]   cnt_next;
  logic [CNT_W-1:0]   n_sq;
  logic [DATA_W:0]    rd_abs;
  logic [DATA_W:0]    rem_sh;
  logic [DATA_W:0]    rem_sub;
  logic signed [2*DATA_W-1:0] p_adj, p, diff;
  logic signed [DATA_W-1:0]   d_sat, q_sat;
  logic [DIM_W-1:0]   n_m1;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (n_used < DIM_W'(2))             n = DIM_W'(2);
    else if (n_used > DIM_W'(MAX_DIM))  n = DIM_W'(MAX_DIM);
    else                                n = n_used;
  end

  assign n_m1     = n - DIM_W'(1);
  assign n_sq     = CNT_W'(n) * CNT_W'(n);
  assign cnt_next = load_count + CNT_W'(1);
  assign rd_abs   = rdata[DATA_W-1] ? -{rdata[DATA_W-1], rdata} : {rdata[DATA_W-1], rdata};

  // One restoring division step: bring down the next dividend bit.
  assign rem_sh  = {rem[DATA_W-1:0], dq[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, piv_mag};

  // Quotient magnitude in dq once the division has run; saturate to 32 bits.
  always_comb begin
    if (!neg && dq > DIV_W'({1'b0, {(DATA_W-1){1'b1}}}))
      q_sat = {1'b0, {(DATA_W-1){1'b1}}};
    else if (neg && dq > DIV_W'({1'b1, {(DATA_W-1){1'b0}}}))
      q_sat = {1'b1, {(DATA_W-1){1'b0}}};
    else if (neg)
      q_sat = DATA_W'(-dq);
    else
      q_sat = DATA_W'(dq);
  end

  // Truncate the product toward zero, subtract and saturate.
  always_comb begin
    p_adj = prod + (prod[2*DATA_W-1] ? (2*DATA_W)'((1 << FRAC_BITS) - 1) : '0);
    p     = p_adj >>> FRAC_BITS;
    diff  = (2*DATA_W)'(awj) - p;
    if (diff > (2*DATA_W)'(64'sd2147483647))
      d_sat = {1'b0, {(DATA_W-1){1'b1}}};
    else if (diff < -(2*DATA_W)'(64'sd2147483648))
      d_sat = {1'b1, {(DATA_W-1){1'b0}}};
    else
      d_sat = DATA_W'(diff);
  end

  always_comb begin
    case (state)
      S_PIV:   raddr = cell_addr(k, k, n);
      S_WK:    raddr = cell_addr(w, k, n);
      S_J:     raddr = cell_addr(k, j, n);
      S_JA:    raddr = cell_addr(w, j, n);
      S_ER:    raddr = cell_addr(r, c, n);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = load_count[ADDR_W-1:0];
    wdata = element;
    if (state == S_IDLE && start) begin
      we = 1'b1;
    end else if (state == S_JW) begin
      we    = 1'b1;
      waddr = cell_addr(w, j, n);
      wdata = d_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      n_used         <= DIM_RESET;
      load_count     <= '0;
      pivot_error    <= 1'b0;
      strobe         <= 1'b0;
      last_of_matrix <= 1'b0;
      k <= '0; w <= '0; j <= '0; r <= '0; c <= '0;
    end else begin
      strobe         <= 1'b0;
      last_of_matrix <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        n_used <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            load_count <= cnt_next;
            if (cnt_next >= n_sq) begin
              k     <= '0;
              state <= S_PIV;
            end
          end
        end
        S_PIV: state <= S_PIVD;
        S_PIVD: begin
          piv     <= rdata;
          piv_mag <= rd_abs[DATA_W-1:0];
          if (rdata == '0) pivot_error <= 1'b1;
          w     <= k + IDX_W'(1);
          state <= S_WK;
        end
        S_WK: state <= S_WKD;
        S_WKD: begin
          if (piv == '0) begin
            fac   <= '0;
            j     <= k;
            state <= S_J;
          end else begin
            dq      <= DIV_W'(rd_abs) << FRAC_BITS;
            rem     <= '0;
            div_cnt <= '0;
            neg     <= rdata[DATA_W-1] ^ piv[DATA_W-1];
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sub[DATA_W]) begin
            rem <= rem_sh;
            dq  <= {dq[DIV_W-2:0], 1'b0};
          end else begin
            rem <= rem_sub;
            dq  <= {dq[DIV_W-2:0], 1'b1};
          end
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_W - 1)) state <= S_DIVF;
        end
        S_DIVF: begin
          fac   <= q_sat;
          j     <= k;
          state <= S_J;
        end
        S_J:  state <= S_JA;
        S_JA: begin
          akj   <= rdata;
          state <= S_JB;
        end
        S_JB: begin
          awj   <= rdata;
          prod  <= fac * akj;
          state <= S_JW;
        end
        S_JW: begin
          if (DIM_W'(j) != n_m1) begin
            j     <= j + IDX_W'(1);
            state <= S_J;
          end else if (DIM_W'(w) != n_m1) begin
            w     <= w + IDX_W'(1);
            state <= S_WK;
          end else if (DIM_W'(k) + DIM_W'(2) < n) begin
            k     <= k + IDX_W'(1);
            state <= S_PIV;
          end else begin
            r     <= '0;
            c     <= '0;
            state <= S_ER;
          end
        end
        S_ER: state <= S_EO;
        S_EO: begin
          strobe     <= 1'b1;
          value      <= (c < r) ? '0 : rdata;
          row_index  <= r;
          col_index  <= c;
          zero_pivot <= pivot_error;
          if (DIM_W'(c) != n_m1) begin
            c     <= c + IDX_W'(1);
            state <= S_ER;
          end else if (DIM_W'(r) != n_m1) begin
            c     <= '0;
            r     <= r + IDX_W'(1);
            state <= S_ER;
          end else begin
            last_of_matrix <= 1'b1;
            load_count     <= '0;
            pivot_error    <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gauss_checker.sv
// ----------------------------------------------------------------------------
// gauss_checker
// Port-level checks on the request and result timing of the top level.
// ----------------------------------------------------------------------------
module gauss_checker
  import gauss_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     strobe,
  input logic                     last_of_matrix,
  input logic                     zero_pivot,
  input logic signed [DATA_W-1:0] value
);

  // Checks the spacing between results within a matrix.
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_matrix |=> !strobe ##1 strobe)
    else $error("result spacing broken");

  // Only the final result of a matrix may appear once the block is idle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_matrix |-> busy)
    else $error("result outside a busy period");

  // Work begins only on an accepted request.
  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");

  // The flag is the same on every result of one matrix.
  a_flag: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_matrix |-> ##2 (zero_pivot == $past(zero_pivot, 2)))
    else $error("zero_pivot changed within a matrix");

  // Every result carries a known value.
  a_known: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !$isunknown({value, zero_pivot}))
    else $error("unknown result value");

endmodule

bind gaussian_elimination_upper gauss_checker u_gauss_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .strobe         (strobe),
  .last_of_matrix (last_of_matrix),
  .zero_pivot     (zero_pivot),
  .value          (value)
);

// File: bench/gaussian_elimination_upper_tb.sv
// ----------------------------------------------------------------------------
// gaussian_elimination_upper_tb
// Drives matrices element by element into the elimination block, writes the
// dimension register between matrices, predicts the upper-triangular result
// and compares every emitted element against that prediction in order.
// ----------------------------------------------------------------------------
module gaussian_elimination_upper_tb;
  import gauss_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
    logic              zp;
  } upper_elem_t;

  typedef struct {
    bit                is_cfg;
    logic [DIM_W-1:0]  dim;
    logic [DATA_W-1:0] elem;
    int unsigned       gap;
  } request_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] element = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [DIM_W-1:0]         cfg_data = '0;
  logic                     strobe;
  logic signed [DATA_W-1:0] value;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic                     last_of_matrix;
  logic                     zero_pivot;

  gaussian_elimination_upper i_dut (
    .clk, .rst, .start, .busy, .element, .cfg_valid, .cfg_ready, .cfg_data,
    .strobe, .value, .row_index, .col_index, .last_of_matrix, .zero_pivot
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic signed [DATA_W-1:0] pred_store [DEPTH];
  int unsigned              pred_loaded;
  logic [DIM_W-1:0]         pred_dim;
  upper_elem_t              expected_elems [$];
  request_t                 pending [$];
  int unsigned              mismatches;

  function automatic longint sat_fix(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int unsigned dim_clamped(logic [DIM_W-1:0] d);
    if (d < 2) return 2;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] slot(int unsigned a);
    return ADDR_W'(a % DEPTH);
  endfunction

  task automatic predict_element(logic [DATA_W-1:0] e);
    int unsigned n, k, w, j, r, c;
    longint piv, fac, prod;
    bit zp;
    upper_elem_t u;
    n = dim_clamped(pred_dim);
    pred_store[slot(pred_loaded)] = e;
    pred_loaded = (pred_loaded + 1) % 128;
    if (pred_loaded < n * n) return;
    zp = 1'b0;
    for (k = 0; k + 1 < n; k++) begin
      piv = longint'(pred_store[slot(k * n + k)]);
      if (piv == 0) zp = 1'b1;
      for (w = k + 1; w < n; w++) begin
        fac = 0;
        if (piv != 0)
          fac = sat_fix((longint'(pred_store[slot(w * n + k)]) <<< FRAC_BITS) / piv);
        for (j = k; j < n; j++) begin
          prod = (fac * longint'(pred_store[slot(k * n + j)])) / (64'sd1 <<< FRAC_BITS);
          pred_store[slot(w * n + j)] =
            DATA_W'(sat_fix(longint'(pred_store[slot(w * n + j)]) - prod));
        end
      end
    end
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        u.val  = (c < r) ? '0 : pred_store[slot(r * n + c)];
        u.row  = IDX_W'(r);
        u.col  = IDX_W'(c);
        u.last = (r + 1 == n) && (c + 1 == n);
        u.zp   = zp;
        expected_elems.push_back(u);
      end
    pred_loaded = 0;
  endtask

  // Driver: one request at a time, inputs change on the falling edge.
  int unsigned gap_left = 0;
  bit          drv_active = 1'b0;
  bit          drv_cfg;
  bit          drain_done = 1'b0;
  bit          busy_seen = 1'b0;
  int unsigned settle = 0;
  request_t    cur;

  // The value of busy that the rising edge saw decides whether a request was taken.
  always @(posedge clk) begin
    busy_seen = busy;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (drv_active && ((drv_cfg && cfg_valid && cfg_ready) ||
                         (!drv_cfg && start && !busy_seen))) begin
        // The request was taken at the previous rising edge.
        drv_active = 1'b0;
        if (drv_cfg) pred_dim = cur.dim;
        else predict_element(cur.elem);
      end
      if (!drv_active && pending.size() > 0) begin
        // A dimension write waits until the block has finished its output.
        if (pending[0].is_cfg && (expected_elems.size() > 0 || busy)) begin
          settle = 0;
        end else if (pending[0].is_cfg && settle < 20) begin
          settle++;
        end else if (gap_left < pending[0].gap) begin
          gap_left++;
        end else begin
          cur = pending.pop_front();
          gap_left = 0;
          settle = 0;
          drv_active = 1'b1;
          drv_cfg = cur.is_cfg;
        end
      end
      if (drv_active && drv_cfg) begin
        cfg_valid <= 1'b1;
        cfg_data  <= cur.dim;
        start     <= 1'b0;
      end else if (drv_active) begin
        start     <= 1'b1;
        element   <= cur.elem;
        cfg_valid <= 1'b0;
      end else begin
        start     <= 1'b0;
        cfg_valid <= 1'b0;
        element   <= $urandom;
      end
      if (!drv_active && pending.size() == 0) drain_done = 1'b1;
    end
  end

  // Monitor: results are sampled at the rising edge.
  always @(posedge clk) begin
    upper_elem_t got, want;
    if (!rst && strobe) begin
      got = '{value, row_index, col_index, last_of_matrix, zero_pivot};
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value=%h row=%0d col=%0d", value, row_index,
                   col_index);
      end else begin
        want = expected_elems.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp val=%h r=%0d c=%0d last=%b zp=%b,",
                      " got val=%h r=%0d c=%0d last=%b zp=%b"},
                     want.val, want.row, want.col, want.last, want.zp,
                     got.val, got.row, got.col, got.last, got.zp);
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_elem(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(0, 1) ? 32'h0 : 32'h0001_0000;
      default: return {{14{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 18'($urandom)};
    endcase
  endfunction

  task automatic add_cfg(logic [DIM_W-1:0] d);
    request_t q;
    q.is_cfg = 1'b1; q.dim = d; q.elem = '0; q.gap = $urandom_range(0, 13);
    pending.push_back(q);
  endtask

  task automatic add_elem(logic [DATA_W-1:0] e, bit bursty);
    request_t q;
    q.is_cfg = 1'b0; q.dim = '0; q.elem = e;
    q.gap = bursty ? 0 : $urandom_range(0, 13);
    pending.push_back(q);
  endtask

  initial begin
    int unsigned count, n, i, mode;
    bit bursty;
    mismatches = 0;
    pred_loaded = 0;
    pred_dim = DIM_RESET;
    // Directed: 2x2 with a zero pivot, 2x2 extremes, then the low register end.
    add_cfg(4'd2);
    add_elem(32'h0, 1'b0); add_elem(32'h7FFF_FFFF, 1'b0);
    add_elem(32'h8000_0000, 1'b0); add_elem(32'h0001_0000, 1'b0);
    add_elem(32'h0000_0001, 1'b1); add_elem(32'h8000_0000, 1'b1);
    add_elem(32'h7FFF_FFFF, 1'b1); add_elem(32'hFFFF_FFFF, 1'b1);
    // Dimension register written as 0 clamps to 2, as 15 clamps to 8; a 3x3 follows.
    add_cfg(4'd0);
    for (i = 0; i < 4; i++) add_elem(rand_elem(i), 1'b0);
    add_cfg(4'd3);
    for (i = 0; i < 9; i++) add_elem(rand_elem(4), 1'b0);
    count = 25;
    while (count < 320) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 1) ? 15 : 8;
      else n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 5);
      add_cfg(DIM_W'(n));
      n = dim_clamped(DIM_W'(n));
      mode = $urandom_range(0, 4);
      bursty = $urandom_range(0, 2) == 0;
      for (i = 0; i < n * n; i++) add_elem(rand_elem($urandom_range(0, 3) == 0 ?
                                                      $urandom_range(0, 4) : mode), bursty);
      count += n * n;
    end
    add_cfg(DIM_RESET);
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (drain_done && expected_elems.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_elems.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/gauss_pkg.sv
rtl/gaussian_elimination_upper.sv
rtl/gauss_checker.sv
bench/gaussian_elimination_upper_tb.sv
